// ===== rtl/pfc_pkg.sv =====
// Shared types and constants for the packet framer with checksum.
package pfc_pkg;

  localparam int unsigned FifoDepthDef = 4;
  localparam int unsigned LenW         = 12;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned WordW        = 16;
  localparam int unsigned CfgW         = 16;
  localparam int unsigned CfgIdxW      = 2;

  // Input kind codes
  localparam logic KindStart = 1'b0;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgVersion    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSourcePort = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDestPort   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPacketType = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  VersionRst    = 8'd12;
  localparam logic [15:0] SourcePortRst = 16'd9438;
  localparam logic [15:0] DestPortRst   = 16'd6260;
  localparam logic [3:0]  PacketTypeRst = 4'd0;

  // Header byte positions, version byte sits at position zero
  localparam logic [2:0] HdrSrcHi  = 3'd1;
  localparam logic [2:0] HdrSrcLo  = 3'd2;
  localparam logic [2:0] HdrDstHi  = 3'd3;
  localparam logic [2:0] HdrDstLo  = 3'd4;
  localparam logic [2:0] HdrLenHi  = 3'd5;
  localparam logic [2:0] HdrLenLo  = 3'd6;

  typedef enum logic {
    OP_START,
    OP_DATA
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            last;
    logic [LenW-1:0] len;
    logic [ByteW-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  version;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [3:0]  packet_type;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_PAD,
    S_CKH,
    S_CKL
  } state_e;

endpackage

// ===== rtl/pfc_front.sv =====
// Front end: accept input transactions, track the open packet, emit commands.
module pfc_front import pfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             kind_i,
  input  logic [LenW-1:0]  payload_length_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             fifo_full_i,
  output logic             in_stall_o,
  output logic             push_o,
  output cmd_t             cmd_o
);

  logic            open_q, open_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic            accept;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;

  always_comb begin
    open_d      = open_q;
    rem_d       = rem_q;
    push_o      = 1'b0;
    cmd_o.op    = OP_START;
    cmd_o.last  = 1'b0;
    cmd_o.len   = payload_length_i;
    cmd_o.data  = data_byte_i;
    if (accept) begin
      if (kind_i == KindStart) begin
        // Abandon any open packet and start over
        push_o = 1'b1;
        open_d = (payload_length_i != '0);
        rem_d  = payload_length_i;
      end else if (open_q) begin
        push_o     = 1'b1;
        cmd_o.op   = OP_DATA;
        cmd_o.last = (rem_q == LenW'(1));
        rem_d      = rem_q - LenW'(1);
        if (rem_q == LenW'(1)) begin
          open_d = 1'b0;
        end
      end
      // Drop payload bytes with no packet open
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      open_q <= open_d;
      rem_q  <= rem_d;
    end
  end

endmodule

// ===== rtl/pfc_fifo.sv =====
// Command queue between the front end and the byte sequencer.
module pfc_fifo import pfc_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/pfc_back.sv =====
// Byte sequencer: header, payload, pad and checksum bytes with running sum.
module pfc_back import pfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             empty_i,
  input  cmd_t             cmd_i,
  output logic             pop_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [ByteW-1:0] out_byte_o,
  output logic             eop_o,
  output logic             eor_o
);

  state_e           state_q, state_d;
  logic [2:0]       idx_q;
  logic [LenW-1:0]  len_q;
  logic             zero_q;
  logic [WordW-1:0] sum_q, sum_d, sum_base;
  logic [ByteW-1:0] held_q, held_d, held_base;
  logic             odd_q, odd_d, odd_base;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             eop_q, eor_q;

  logic             advance;
  logic             emit, fold, clear;
  logic [ByteW-1:0] byte_d;
  logic             eop_d, eor_d;
  logic [WordW:0]   add_raw;
  logic [ByteW-1:0] hdr_byte;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = (state_q == S_IDLE) && !empty_i && advance;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          if (cmd_i.op == OP_START) begin
            state_d = S_HDR;
          end else if (cmd_i.last) begin
            state_d = odd_q ? S_CKH : S_PAD;
          end
        end
      end
      S_HDR: begin
        if (idx_q == HdrLenLo) begin
          state_d = zero_q ? S_PAD : S_IDLE;
        end
      end
      S_PAD:   state_d = S_CKH;
      S_CKH:   state_d = S_CKL;
      S_CKL:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (idx_q)
      HdrSrcHi: hdr_byte = cfg_i.source_port[15:8];
      HdrSrcLo: hdr_byte = cfg_i.source_port[7:0];
      HdrDstHi: hdr_byte = cfg_i.dest_port[15:8];
      HdrDstLo: hdr_byte = cfg_i.dest_port[7:0];
      HdrLenHi: hdr_byte = {cfg_i.packet_type, len_q[11:8]};
      HdrLenLo: hdr_byte = len_q[7:0];
      default:  hdr_byte = cfg_i.version;
    endcase
  end

  // Outputs of each state
  always_comb begin
    emit   = 1'b0;
    fold   = 1'b0;
    clear  = 1'b0;
    byte_d = '0;
    eop_d  = 1'b0;
    eor_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        emit = !empty_i;
        fold = !empty_i;
        if (cmd_i.op == OP_START) begin
          clear  = 1'b1;
          byte_d = cfg_i.version;
        end else begin
          byte_d = cmd_i.data;
          eor_d  = !cmd_i.last;
        end
      end
      S_HDR: begin
        emit   = 1'b1;
        fold   = 1'b1;
        byte_d = hdr_byte;
        eor_d  = (idx_q == HdrLenLo) && !zero_q;
      end
      S_PAD: begin
        emit = 1'b1;
        fold = 1'b1;
      end
      S_CKH: begin
        emit   = 1'b1;
        byte_d = ~sum_q[15:8];
      end
      S_CKL: begin
        emit   = 1'b1;
        byte_d = ~sum_q[7:0];
        eop_d  = 1'b1;
        eor_d  = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // Ones'-complement sum with end-around carry
  assign sum_base  = clear ? '0 : sum_q;
  assign held_base = clear ? '0 : held_q;
  assign odd_base  = clear ? 1'b0 : odd_q;
  assign add_raw   = {1'b0, sum_base} + {1'b0, held_base, byte_d};

  always_comb begin
    sum_d  = sum_base;
    held_d = held_base;
    odd_d  = !odd_base;
    if (odd_base) begin
      sum_d = add_raw[WordW-1:0] + WordW'(add_raw[WordW]);
    end else begin
      held_d = byte_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      zero_q      <= 1'b0;
      sum_q       <= '0;
      held_q      <= '0;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      eop_q       <= 1'b0;
      eor_q       <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      out_valid_q <= emit;
      eop_q       <= eop_d;
      eor_q       <= eor_d;
      if (fold) begin
        sum_q  <= sum_d;
        held_q <= held_d;
        odd_q  <= odd_d;
      end
      if (pop_o && cmd_i.op == OP_START) begin
        idx_q  <= HdrSrcHi;
        zero_q <= (cmd_i.len == '0);
      end else if (state_q == S_HDR) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= byte_d;
      if (pop_o && cmd_i.op == OP_START) begin
        len_q <= cmd_i.len;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign eop_o       = eop_q;
  assign eor_o       = eor_q;

  a_eop_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && eop_q |-> eor_q)
    else $error("end of packet without end of run");

  a_ckl_loads_eop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CKL && advance |=> out_valid_q && eop_q)
    else $error("low checksum byte not marked end of packet");

  a_eop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && eop_q |-> state_q == S_IDLE)
    else $error("sequencer busy while end of packet pending");

  a_pad_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PAD |-> odd_q)
    else $error("pad byte with even byte count");

endmodule

// ===== rtl/packet_framer_with_checksum.sv =====
// Top level of the packet framer with Internet checksum.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------------
//  in       | in        | in_valid_i / in_stall_o   | kind_i, payload_length_i, data_byte_i
//  out      | out       | out_valid_o / out_stall_i | out_byte_o, end_of_packet_o,
//           |           |                           | end_of_run_o
//  cfg      | in        | cfg_we_i                  | cfg_index_i, cfg_data_i
//
//  One output byte per cycle while out_stall_i is low. A payload transaction yields
//  1 byte, or 3 to 4 on the last byte of a packet; a start transaction yields 7 header
//  bytes, 10 for an empty packet. The byte sequencer sets the rate: one byte per cycle
//  through its output register, held while out_stall_i is high. The command queue
//  (FifoDepth entries) takes input while the sequencer is busy or stalled; in_stall_o
//  rises only when that queue is full. Reset clears the queue, the open packet and the
//  checksum, and loads register defaults.
module packet_framer_with_checksum import pfc_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // Input transactions
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [LenW-1:0]    payload_length_i,
  input  logic [ByteW-1:0]   data_byte_i,
  // Output transactions
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   out_byte_o,
  output logic               end_of_packet_o,
  output logic               end_of_run_o
);

  cfg_t cfg_q;
  logic fifo_push, fifo_pop, fifo_full, fifo_empty;
  cmd_t push_cmd, head_cmd;

  // Register file: mask each write to the register's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.version     <= VersionRst;
      cfg_q.source_port <= SourcePortRst;
      cfg_q.dest_port   <= DestPortRst;
      cfg_q.packet_type <= PacketTypeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgVersion:    cfg_q.version     <= cfg_data_i[7:0];
        CfgSourcePort: cfg_q.source_port <= cfg_data_i[15:0];
        CfgDestPort:   cfg_q.dest_port   <= cfg_data_i[15:0];
        CfgPacketType: cfg_q.packet_type <= cfg_data_i[3:0];
        default:       cfg_q.version     <= cfg_q.version;
      endcase
    end
  end

  // Classify transactions; drop stray payload bytes before the queue
  pfc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .kind_i           (kind_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .fifo_full_i      (fifo_full),
    .in_stall_o       (in_stall_o),
    .push_o           (fifo_push),
    .cmd_o            (push_cmd)
  );

  // Decouple the input side from the byte sequencer
  pfc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (push_cmd),
    .pop_i   (fifo_pop),
    .rdata_o (head_cmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  // Expand commands into wire bytes and fold them into the checksum
  pfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (fifo_empty),
    .cmd_i       (head_cmd),
    .pop_o       (fifo_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .eop_o       (end_of_packet_o),
    .eor_o       (end_of_run_o)
  );

endmodule

// ===== tb/tb_packet_framer_with_checksum.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the packet framer: predicts every framed byte and its checksum.
module tb_packet_framer_with_checksum;
  import pfc_pkg::*;

  localparam int unsigned CycleLimit    = 600000;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned ItemsPerPhase = 112;

  // One byte on the wire with its two flags
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             eop;
    logic             eor;
  } wire_byte_t;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i      = CfgVersion;
  logic [CfgW-1:0]    cfg_data_i       = '0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic               kind_i           = KindStart;
  logic [LenW-1:0]    payload_length_i = '0;
  logic [ByteW-1:0]   data_byte_i      = '0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic [ByteW-1:0]   out_byte_o;
  logic               end_of_packet_o;
  logic               end_of_run_o;

  packet_framer_with_checksum dut (.*);

  always #6 clk_i = ~clk_i;

  // Predicted copy of the registers and the framing state
  logic [7:0]      reg_version  = VersionRst;
  logic [15:0]     reg_src_port = SourcePortRst;
  logic [15:0]     reg_dst_port = DestPortRst;
  logic [3:0]      reg_pkt_type = PacketTypeRst;
  logic [15:0]     sum_word     = '0;
  logic [7:0]      high_byte    = '0;
  logic            high_pending = 1'b0;
  logic [LenW-1:0] bytes_left   = '0;
  logic            packet_live  = 1'b0;

  wire_byte_t  framed_bytes[$];
  int unsigned productive_items = 0;
  int unsigned mismatch_count   = 0;
  int unsigned cycle_count      = 0;
  bit          quiet_links      = 1'b0;
  int unsigned stall_hold       = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void queue_byte(input logic [7:0] b, input logic eop);
    wire_byte_t entry;
    entry.data = b;
    entry.eop  = eop;
    entry.eor  = 1'b0;
    framed_bytes.push_back(entry);
  endfunction

  // Emit one byte and fold it into the ones'-complement sum, big-endian pairs
  function automatic void add_wire_byte(input logic [7:0] b);
    logic [16:0] total;
    if (!high_pending) begin
      high_byte    = b;
      high_pending = 1'b1;
    end else begin
      total        = {1'b0, sum_word} + {1'b0, high_byte, b};
      sum_word     = total[15:0] + {15'd0, total[16]};  // end-around carry
      high_pending = 1'b0;
    end
    queue_byte(b, 1'b0);
  endfunction

  function automatic void clear_checksum();
    sum_word     = '0;
    high_byte    = '0;
    high_pending = 1'b0;
  endfunction

  // Pad to an even count, append the checksum, close the packet
  function automatic void close_packet();
    logic [15:0] csum;
    if (high_pending) add_wire_byte(8'h00);
    csum = ~sum_word;
    queue_byte(csum[15:8], 1'b0);
    queue_byte(csum[7:0], 1'b1);
    packet_live = 1'b0;
    bytes_left  = '0;
    clear_checksum();
  endfunction

  function automatic void frame_predict(input op_e kind, input logic [LenW-1:0] len,
                                        input logic [ByteW-1:0] data);
    int unsigned first;
    logic [15:0] type_len;
    wire_byte_t  tail;
    first    = framed_bytes.size();
    type_len = {reg_pkt_type, len};
    if (kind == OP_START) begin
      // A start abandons any open packet without a trailer
      clear_checksum();
      packet_live = 1'b1;
      bytes_left  = len;
      add_wire_byte(reg_version);
      add_wire_byte(reg_src_port[15:8]);
      add_wire_byte(reg_src_port[7:0]);
      add_wire_byte(reg_dst_port[15:8]);
      add_wire_byte(reg_dst_port[7:0]);
      add_wire_byte(type_len[15:8]);
      add_wire_byte(type_len[7:0]);
      if (bytes_left == '0) close_packet();
    end else if (packet_live && bytes_left != '0) begin
      add_wire_byte(data);
      bytes_left = bytes_left - 1'b1;
      if (bytes_left == '0) close_packet();
    end
    // Flag the last byte caused by this transaction
    if (framed_bytes.size() > first) begin
      tail     = framed_bytes[framed_bytes.size() - 1];
      tail.eor = 1'b1;
      framed_bytes[framed_bytes.size() - 1] = tail;
      productive_items++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Random timing
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (quiet_links) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 96) return $urandom_range(8, 4);
    return $urandom_range(30, 15);
  endfunction

  function automatic int unsigned hold_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) return $urandom_range(2);
    if (roll < 95) return $urandom_range(9, 3);
    return $urandom_range(30, 15);
  endfunction

  // Receiver back-pressure: hold each level for a random number of cycles
  always @(negedge clk_i) begin
    if (quiet_links) begin
      out_stall_i <= 1'b0;
      stall_hold  <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < 30);
      stall_hold  <= hold_len();
    end
  end

  // ---------------------------------------------------------------------------
  // Output checker: compare each output transaction with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    wire_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (framed_bytes.size() == 0) begin
        mismatch_count++;
        $display("%0t: output transaction with nothing expected: byte %h eop %b eor %b",
                 $time, out_byte_o, end_of_packet_o, end_of_run_o);
      end else begin
        want = framed_bytes.pop_front();
        if (out_byte_o !== want.data) begin
          mismatch_count++;
          $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte_o);
        end
        if (end_of_packet_o !== want.eop) begin
          mismatch_count++;
          $display("%0t: end_of_packet expected %b actual %b", $time, want.eop,
                   end_of_packet_o);
        end
        if (end_of_run_o !== want.eor) begin
          mismatch_count++;
          $display("%0t: end_of_run expected %b actual %b", $time, want.eor, end_of_run_o);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("packet_framer_with_checksum verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------
  // Send one input transaction; valid stays high afterwards until the next call
  task automatic send_item(input op_e kind, input logic [LenW-1:0] len,
                           input logic [ByteW-1:0] data);
    int unsigned gap;
    gap = idle_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= kind;
    payload_length_i <= len;
    data_byte_i      <= data;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    frame_predict(kind, len, data);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Pause until every predicted byte has come out
  task automatic drain_output();
    release_input();
    while (framed_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then leave the inputs idle before going on
  task automatic settle();
    drain_output();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      CfgVersion:    reg_version  = value[7:0];
      CfgSourcePort: reg_src_port = value[15:0];
      CfgDestPort:   reg_dst_port = value[15:0];
      CfgPacketType: reg_pkt_type = value[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_regs(input logic [CfgW-1:0] ver, input logic [CfgW-1:0] src,
                              input logic [CfgW-1:0] dst, input logic [CfgW-1:0] ptype);
    settle();
    write_reg(CfgVersion, ver);
    write_reg(CfgSourcePort, src);
    write_reg(CfgDestPort, dst);
    write_reg(CfgPacketType, ptype);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset register values; empty packet, even and odd totals
  task automatic test_reset_defaults();
    send_item(OP_START, 12'd0, 8'hA5);     // header, pad and checksum in one go
    send_item(OP_START, 12'd1, 8'h00);
    send_item(OP_DATA, 12'hFFF, 8'hFF);    // 8 bytes in all: no pad
    send_item(OP_START, 12'd2, 8'hFF);
    send_item(OP_DATA, 12'd0, 8'h00);
    send_item(OP_DATA, 12'd0, 8'h80);      // 9 bytes in all: pad
  endtask

  // Payload transactions with no packet open: drop silently
  task automatic test_stray_bytes();
    send_item(OP_DATA, 12'd0, 8'h5A);
    send_item(OP_DATA, 12'hABC, 8'hC3);
  endtask

  // Longest length, then abandon it with a fresh start
  task automatic test_abandon();
    send_item(OP_START, 12'hFFF, 8'h00);
    send_item(OP_DATA, 12'd0, 8'h12);
    send_item(OP_DATA, 12'd0, 8'hEF);
    send_item(OP_START, 12'd3, 8'hFF);
    send_item(OP_DATA, 12'd0, 8'hFF);
    send_item(OP_DATA, 12'd0, 8'h00);
    send_item(OP_DATA, 12'd0, 8'h7E);
  endtask

  // All-ones writes (narrow registers drop the upper bits), then all zeros
  task automatic test_register_extremes();
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_START, 12'd1, 8'h3C);
    send_item(OP_DATA, 12'd5, 8'hFF);      // many end-around carries
    send_item(OP_START, 12'd0, 8'h00);
    program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_START, 12'd0, 8'hFF);     // checksum of all zeros
  endtask

  function automatic logic [LenW-1:0] packet_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return LenW'($urandom_range(12));
    if (roll < 95) return LenW'($urandom_range(64, 13));
    return LenW'($urandom_range(300, 100));
  endfunction

  // Mostly complete packets with random content; some cut short, some stray bytes
  task automatic test_random_traffic(input bit steady, input int unsigned budget);
    int unsigned goal;
    int unsigned roll;
    int unsigned cut;
    logic [LenW-1:0] len;
    bit paused;
    program_regs(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom));
    quiet_links = steady;
    goal   = productive_items + budget;
    paused = 1'b0;
    while (productive_items < goal) begin
      // Hold the sender once per phase until the output is empty
      if (!paused && productive_items + budget / 2 >= goal) begin
        drain_output();
        paused = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 6) begin
        repeat ($urandom_range(2, 1))
          send_item(OP_DATA, LenW'($urandom), ByteW'($urandom));
      end else if (roll < 16) begin
        len = LenW'($urandom_range(4095, 8));
        cut = $urandom_range(5);
        send_item(OP_START, len, ByteW'($urandom));
        repeat (cut) send_item(OP_DATA, LenW'($urandom), ByteW'($urandom));
      end else begin
        len = packet_len();
        send_item(OP_START, len, ByteW'($urandom));
        // Stop at the phase budget; a later start abandons the rest
        for (int unsigned i = 0; i < len && productive_items < goal; i++) begin
          send_item(OP_DATA, LenW'($urandom), ByteW'($urandom));
        end
      end
    end
    quiet_links = 1'b0;
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_stray_bytes();
    test_abandon();
    test_register_extremes();
    test_random_traffic(1'b0, ItemsPerPhase);
    test_random_traffic(1'b1, ItemsPerPhase);
    test_random_traffic(1'b0, ItemsPerPhase);
    test_random_traffic(1'b0, ItemsPerPhase);

    settle();
    if (mismatch_count == 0) begin
      $display("packet_framer_with_checksum verification clean");
    end else begin
      $display("packet_framer_with_checksum verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pfc_pkg.sv
rtl/pfc_front.sv
rtl/pfc_fifo.sv
rtl/pfc_back.sv
rtl/packet_framer_with_checksum.sv
tb/tb_packet_framer_with_checksum.sv
